>>> rtl/dsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsc_pkg
// Shared types and constants for the distance sample conditioner.
// ----------------------------------------------------------------------------
package dsc_pkg;

  // Q16 fraction: 16 quotient bits plus one bit for the saturated 1.0 value
  localparam int unsigned Q_BITS    = 16;
  localparam int unsigned FRAC_BITS = Q_BITS + 1;
  localparam logic [FRAC_BITS-1:0] Q16_ONE = FRAC_BITS'(1) << Q_BITS;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned SMOOTH_W   = 9;
  localparam int unsigned TREG_W     = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INVERT    = 3'd0,
    CFG_SMOOTHING = 3'd1,
    CFG_MIN       = 3'd2,
    CFG_MAX       = 3'd3,
    CFG_THRESHOLD = 3'd4,
    CFG_DEBOUNCE  = 3'd5,
    CFG_COOLDOWN  = 3'd6,
    CFG_DEAD_BAND = 3'd7
  } cfg_idx_e;

  localparam logic REPORT_SWITCH = 1'b0;
  localparam logic REPORT_ANALOG = 1'b1;

endpackage

>>> rtl/dsc_frac_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsc_frac_div
// Iterative Q16 fraction unit: pos / (max - min), one quotient bit per cycle,
// saturated at 1.0. A zero range gives 1.0, a negative range gives 0.
// ----------------------------------------------------------------------------
module dsc_frac_div
  import dsc_pkg::*;
#(
  parameter int unsigned POS_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [POS_BITS-1:0]  pos_i,
  input  logic [POS_BITS-1:0]  min_i,
  input  logic [POS_BITS-1:0]  max_i,
  output logic                 done_o,
  output logic [FRAC_BITS-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(Q_BITS);

  typedef enum logic [1:0] {
    D_IDLE,
    D_CHECK,
    D_RUN
  } div_state_e;

  div_state_e            state_q;
  logic [POS_BITS-1:0]   pos_q;
  logic [POS_BITS:0]     range_q;   // MSB set: max below min
  logic [POS_BITS:0]     rem_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [FRAC_BITS-1:0]  quot_q;
  logic                  done_q;

  logic [POS_BITS:0]     rem_shl;
  logic                  rem_ge;

  // remainder stays below range, so the doubled value fits
  assign rem_shl = {rem_q[POS_BITS-1:0], 1'b0};
  assign rem_ge  = rem_shl >= range_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      pos_q   <= '0;
      range_q <= '0;
      rem_q   <= '0;
      cnt_q   <= '0;
      quot_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        D_IDLE: begin
          if (start_i) begin
            pos_q   <= pos_i;
            range_q <= {1'b0, max_i} - {1'b0, min_i};
            state_q <= D_CHECK;
          end
        end
        D_CHECK: begin
          if (range_q[POS_BITS]) begin
            quot_q  <= '0;
            done_q  <= 1'b1;
            state_q <= D_IDLE;
          end else if (range_q == '0 || {1'b0, pos_q} >= range_q) begin
            quot_q  <= Q16_ONE;
            done_q  <= 1'b1;
            state_q <= D_IDLE;
          end else begin
            rem_q   <= {1'b0, pos_q};
            quot_q  <= '0;
            cnt_q   <= '0;
            state_q <= D_RUN;
          end
        end
        D_RUN: begin
          rem_q  <= rem_ge ? (rem_shl - range_q) : rem_shl;
          quot_q <= {quot_q[FRAC_BITS-2:0], rem_ge};
          cnt_q  <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(Q_BITS - 1)) begin
            done_q  <= 1'b1;
            state_q <= D_IDLE;
          end
        end
        default: state_q <= D_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

>>> rtl/distance_sample_conditioner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distance_sample_conditioner
// Mirrors, smooths and clamps distance samples; reports either a debounced
// switch state or the analog position with its Q16 fraction of the range.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (sample_i, now_tick_i) transfers when in_valid_i is high and
//   in_stall_o is low. in_stall_o stays high while an item is in work.
//   Output channel transfers when out_valid_o is high and out_stall_i is low;
//   each item yields zero or one result.
//   Config writes transfer on cfg_valid_i & cfg_ready_o, index per register.
// Sequence:
//   One item at a time. Mirror at input transfer, then smoothing in the
//   S_MUL_LAST and S_MUL_NEW states through one shared 9-bit multiplier
//   (skipped when smoothing is off), a clamp state, then S_SW_CAND,
//   S_SW_STABLE and S_SW_DECIDE for switch mode or S_AN_DIFF for analog mode.
//   A reported analog value then runs the fraction divider (range check,
//   16 quotient bits, hand back; the range check alone may settle it),
//   and any report then loads the output register from S_DONE.
//   A finished result sits in the output register; a new item is accepted
//   while it waits, and the next result holds until the register frees up.
// Reset: configuration returns to its defaults, all state clears.
// ----------------------------------------------------------------------------
module distance_sample_conditioner
  import dsc_pkg::*;
#(
  parameter int unsigned POSITION_BITS = 16,
  parameter int unsigned TICK_BITS     = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // sample channel
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [POSITION_BITS-1:0] sample_i,
  input  logic [TICK_BITS-1:0]     now_tick_i,
  // result channel
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     report_kind_o,
  output logic                     switch_state_o,
  output logic [POSITION_BITS-1:0] position_o,
  output logic [FRAC_BITS-1:0]     fraction_o,
  // configuration channel
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned P     = POSITION_BITS;
  localparam int unsigned ACC_W = P + 8;
  localparam int unsigned CMP_W = (TICK_BITS > TREG_W) ? TICK_BITS : TREG_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_LAST,
    S_MUL_NEW,
    S_CLAMP,
    S_SW_CAND,
    S_SW_STABLE,
    S_SW_DECIDE,
    S_AN_DIFF,
    S_AN_DIV,
    S_DONE
  } state_e;

  state_e                 state_q;

  // configuration
  logic                   invert_q;
  logic [SMOOTH_W-1:0]    smooth_q;
  logic [P-1:0]           min_q;
  logic [P-1:0]           max_q;
  logic [P-1:0]           thr_q;
  logic [TREG_W-1:0]      debounce_q;
  logic [TREG_W-1:0]      cooldown_q;
  logic [P-1:0]           dead_band_q;

  // block state
  logic [P-1:0]           last_pos_q;
  logic                   cand_q;
  logic [TICK_BITS-1:0]   cand_tick_q;
  logic                   acc_state_q;
  logic                   cooling_q;
  logic [TICK_BITS-1:0]   cd_start_q;

  // item in work
  logic [P-1:0]           pos_q;
  logic [TICK_BITS-1:0]   now_q;
  logic [ACC_W-1:0]       acc_q;
  logic                   stable_q;
  logic                   res_kind_q;
  logic                   res_state_q;
  logic [FRAC_BITS-1:0]   res_frac_q;

  // output register
  logic                   out_valid_q;
  logic                   out_kind_q;
  logic                   out_state_q;
  logic [P-1:0]           out_pos_q;
  logic [FRAC_BITS-1:0]   out_frac_q;

  logic                   in_xfer;
  logic                   cfg_xfer;
  logic                   out_free;
  logic [P-1:0]           mirrored;
  logic [P-1:0]           mul_a;
  logic [SMOOTH_W-1:0]    mul_b;
  logic [P+SMOOTH_W-1:0]  prod;
  logic [ACC_W-1:0]       smooth_sum;
  logic                   raw_state;
  logic [TICK_BITS-1:0]   since_diff;
  logic [TICK_BITS-1:0]   cd_diff;
  logic                   cd_expired;
  logic [P-1:0]           pos_delta;
  logic                   div_start;
  logic                   div_done;
  logic [FRAC_BITS-1:0]   div_quot;

  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign cfg_xfer    = cfg_valid_i && cfg_ready_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign mirrored = (sample_i > max_q) ? '0 : (max_q - sample_i);

  // shared multiplier: last * (256 - f), then new * f
  assign mul_a      = (state_q == S_MUL_LAST) ? last_pos_q : pos_q;
  assign mul_b      = (state_q == S_MUL_LAST) ? (SMOOTH_W'(256) - smooth_q) : smooth_q;
  assign prod       = mul_a * mul_b;
  assign smooth_sum = acc_q + prod[ACC_W-1:0];

  assign raw_state  = (pos_q > thr_q) ? invert_q : !invert_q;
  assign since_diff = now_q - cand_tick_q;
  assign cd_diff    = now_q - cd_start_q;
  assign cd_expired = CMP_W'(cd_diff) >= CMP_W'(cooldown_q);

  assign pos_delta  = (pos_q > last_pos_q) ? (pos_q - last_pos_q) : (last_pos_q - pos_q);
  assign div_start  = (state_q == S_AN_DIFF) && (thr_q == '0) && (pos_delta > dead_band_q);

  dsc_frac_div #(
    .POS_BITS (P)
  ) u_frac_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .pos_i   (pos_q),
    .min_i   (min_q),
    .max_i   (max_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      invert_q     <= 1'b0;
      smooth_q     <= SMOOTH_W'(256);
      min_q        <= '0;
      max_q        <= '1;
      thr_q        <= '0;
      debounce_q   <= '0;
      cooldown_q   <= '0;
      dead_band_q  <= '0;
      last_pos_q   <= '0;
      cand_q       <= 1'b0;
      cand_tick_q  <= '0;
      acc_state_q  <= 1'b0;
      cooling_q    <= 1'b0;
      cd_start_q   <= '0;
      pos_q        <= '0;
      now_q        <= '0;
      acc_q        <= '0;
      stable_q     <= 1'b0;
      res_kind_q   <= 1'b0;
      res_state_q  <= 1'b0;
      res_frac_q   <= '0;
      out_valid_q  <= 1'b0;
      out_kind_q   <= 1'b0;
      out_state_q  <= 1'b0;
      out_pos_q    <= '0;
      out_frac_q   <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_xfer) begin
        case (cfg_index_i)
          CFG_INVERT:    invert_q    <= cfg_data_i[0];
          CFG_SMOOTHING: smooth_q    <= cfg_data_i[SMOOTH_W-1:0];
          CFG_MIN:       min_q       <= cfg_data_i[P-1:0];
          CFG_MAX:       max_q       <= cfg_data_i[P-1:0];
          CFG_THRESHOLD: thr_q       <= cfg_data_i[P-1:0];
          CFG_DEBOUNCE:  debounce_q  <= cfg_data_i[TREG_W-1:0];
          CFG_COOLDOWN:  cooldown_q  <= cfg_data_i[TREG_W-1:0];
          CFG_DEAD_BAND: dead_band_q <= cfg_data_i[P-1:0];
          default: ;
        endcase
      end

      case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            pos_q   <= invert_q ? mirrored : sample_i;
            now_q   <= now_tick_i;
            // factor of 256 and above means no smoothing
            state_q <= smooth_q[SMOOTH_W-1] ? S_CLAMP : S_MUL_LAST;
          end
        end
        S_MUL_LAST: begin
          acc_q   <= prod[ACC_W-1:0];
          state_q <= S_MUL_NEW;
        end
        S_MUL_NEW: begin
          pos_q   <= smooth_sum[ACC_W-1:8];
          state_q <= S_CLAMP;
        end
        S_CLAMP: begin
          if (pos_q > max_q) begin
            pos_q <= max_q;
          end else if (pos_q < min_q) begin
            pos_q <= min_q;
          end
          state_q <= (thr_q != '0) ? S_SW_CAND : S_AN_DIFF;
        end
        S_SW_CAND: begin
          if (raw_state != cand_q) begin
            cand_q      <= raw_state;
            cand_tick_q <= now_q;
          end
          state_q <= S_SW_STABLE;
        end
        S_SW_STABLE: begin
          stable_q <= CMP_W'(since_diff) >= CMP_W'(debounce_q);
          state_q  <= S_SW_DECIDE;
        end
        S_SW_DECIDE: begin
          if (cooling_q && stable_q && cand_q && !acc_state_q) begin
            // stable rise during cooldown restarts it silently
            cd_start_q  <= now_q;
            acc_state_q <= 1'b1;
            last_pos_q  <= pos_q;
            state_q     <= S_IDLE;
          end else if (cooling_q && !cd_expired) begin
            last_pos_q <= pos_q;
            state_q    <= S_IDLE;
          end else begin
            if (cooling_q) begin
              cooling_q <= 1'b0;
            end
            if (stable_q && (cand_q != acc_state_q)) begin
              acc_state_q <= cand_q;
              if (cand_q && (cooldown_q != '0)) begin
                cooling_q  <= 1'b1;
                cd_start_q <= now_q;
              end
              res_kind_q  <= REPORT_SWITCH;
              res_state_q <= cand_q;
              res_frac_q  <= '0;
              state_q     <= S_DONE;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        S_AN_DIFF: begin
          if (div_start) begin
            last_pos_q <= pos_q;
            state_q    <= S_AN_DIV;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_AN_DIV: begin
          if (div_done) begin
            res_kind_q  <= REPORT_ANALOG;
            res_state_q <= 1'b0;
            res_frac_q  <= div_quot;
            state_q     <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_kind_q  <= res_kind_q;
            out_state_q <= res_state_q;
            out_pos_q   <= (res_kind_q == REPORT_ANALOG) ? pos_q : '0;
            out_frac_q  <= res_frac_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign report_kind_o  = out_kind_q;
  assign switch_state_o = out_state_q;
  assign position_o     = out_pos_q;
  assign fraction_o     = out_frac_q;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> in_stall_o)
    else $error("input accepted but block not busy next cycle");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_DONE))
    else $error("result appeared without a finished item");

  a_switch_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (report_kind_o == REPORT_SWITCH) |-> (position_o == '0) && (fraction_o == '0))
    else $error("switch report carries analog payload");

  a_frac_saturated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (div_quot <= Q16_ONE))
    else $error("fraction above 1.0");

  a_div_only_analog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_AN_DIV) |-> (thr_q == '0))
    else $error("divider in use in threshold mode");
`endif

endmodule
